// ===== design/fprc_pkg.sv =====
// Shared types, constants and the CRC16-CCITT byte update for the packet receiver.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fprc_pkg;

    localparam logic [7:0]  BYTE_SOH   = 8'h01;
    localparam logic [7:0]  BYTE_STX   = 8'h02;
    localparam logic [7:0]  BYTE_ETX   = 8'h03;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] SEED_RESET = 16'hFFFF;
    localparam int          MinPacket  = 7;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BAD_STX = 3'd1,
        ST_BAD_LEN = 3'd2,
        ST_BAD_ETX = 3'd3,
        ST_BAD_CRC = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_FEED    = 3'd1,
        OP_PAYLOAD = 3'd2,
        OP_STATUS  = 3'd3,
        OP_CRC_HI  = 3'd4,
        OP_CRC_LO  = 3'd5
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] rx_byte;
        status_t    status;
    } cmd_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== design/fprc_front.sv =====
// Framing FSM: drops bytes until 0x01, then makes a back end command for each byte.
// Depends on fprc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fprc_front
    import fprc_pkg::*;
#(
    parameter int MAX_PACKET = 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    input  wire logic [7:0] in_byte,
    output cmd_t            cmd,
    output logic            cmd_push
);

    localparam int CntW = $clog2(MAX_PACKET + 1);

    typedef enum logic [7:0] {
        PH_HUNT   = 8'b0000_0001,
        PH_LEN_HI = 8'b0000_0010,
        PH_LEN_LO = 8'b0000_0100,
        PH_STX    = 8'b0000_1000,
        PH_MSG    = 8'b0001_0000,
        PH_ETX    = 8'b0010_0000,
        PH_CRC_HI = 8'b0100_0000,
        PH_CRC_LO = 8'b1000_0000
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [7:0]      len_hi_reg, len_hi_next;
    logic [CntW-1:0] remain_reg, remain_next;
    logic [15:0]     full_len;

    assign full_len = {len_hi_reg, in_byte};

    always_comb begin
        phase_next  = phase_reg;
        len_hi_next = len_hi_reg;
        remain_next = remain_reg;
        cmd_push    = 1'b0;
        cmd.op      = OP_FEED;
        cmd.rx_byte = in_byte;
        cmd.status  = ST_OK;
        if (in_valid) begin
            cmd_push = 1'b1;
            unique case (phase_reg)
                PH_HUNT: begin
                    cmd.op = OP_START;
                    if (in_byte == BYTE_SOH) begin
                        phase_next = PH_LEN_HI;
                    end else begin
                        cmd_push = 1'b0;
                    end
                end
                PH_LEN_HI: begin
                    len_hi_next = in_byte;
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    if (full_len < 16'(MinPacket) || full_len > 16'(MAX_PACKET)) begin
                        cmd.op     = OP_STATUS;
                        cmd.status = ST_BAD_LEN;
                        phase_next = PH_HUNT;
                    end else begin
                        remain_next = CntW'(full_len - 16'(MinPacket));
                        phase_next  = PH_STX;
                    end
                end
                PH_STX: begin
                    if (in_byte != BYTE_STX) begin
                        cmd.op     = OP_STATUS;
                        cmd.status = ST_BAD_STX;
                        phase_next = PH_HUNT;
                    end else if (remain_reg == '0) begin
                        phase_next = PH_ETX;
                    end else begin
                        phase_next = PH_MSG;
                    end
                end
                PH_MSG: begin
                    cmd.op      = OP_PAYLOAD;
                    remain_next = remain_reg - CntW'(1);
                    if (remain_reg == CntW'(1)) begin
                        phase_next = PH_ETX;
                    end
                end
                PH_ETX: begin
                    if (in_byte != BYTE_ETX) begin
                        cmd.op     = OP_STATUS;
                        cmd.status = ST_BAD_ETX;
                        phase_next = PH_HUNT;
                    end else begin
                        phase_next = PH_CRC_HI;
                    end
                end
                PH_CRC_HI: begin
                    cmd.op     = OP_CRC_HI;
                    phase_next = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    cmd.op     = OP_CRC_LO;
                    phase_next = PH_HUNT;
                end
                default: begin
                    cmd_push   = 1'b0;
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
        end else begin
            phase_reg <= phase_next;
        end
        len_hi_reg <= len_hi_next;
        remain_reg <= remain_next;
    end

endmodule
`default_nettype wire

// ===== design/fprc_cmd_fifo.sv =====
// Two-entry command queue between the framing front end and the CRC back end.
// Depends on fprc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fprc_cmd_fifo
    import fprc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    output logic      empty,
    input  wire logic pop,
    output cmd_t      pop_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== design/fprc_back.sv =====
// CRC accumulation, check and result register; executes commands from the queue.
// Depends on fprc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fprc_back
    import fprc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [15:0] crc_seed,
    input  wire logic        cmd_valid,
    input  wire cmd_t        cmd,
    output logic             cmd_pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             out_kind,
    output logic [7:0]       out_data,
    output logic [2:0]       out_status
);

    logic        valid_reg, valid_next;
    logic        kind_reg, kind_next;
    logic [7:0]  data_reg, data_next;
    logic [2:0]  status_reg, status_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_hi_reg, crc_hi_next;
    logic        slot_free;
    logic [15:0] crc_in;

    assign slot_free = !valid_reg || out_ready;
    assign cmd_pop   = cmd_valid && slot_free;
    assign crc_in    = (cmd.op == OP_START) ? crc_seed : crc_reg;

    always_comb begin
        valid_next  = valid_reg && !out_ready;
        kind_next   = kind_reg;
        data_next   = data_reg;
        status_next = status_reg;
        crc_next    = crc_reg;
        crc_hi_next = crc_hi_reg;
        if (cmd_pop) begin
            unique case (cmd.op)
                OP_START, OP_FEED: begin
                    crc_next = crc_feed(crc_in, cmd.rx_byte);
                end
                OP_PAYLOAD: begin
                    crc_next    = crc_feed(crc_in, cmd.rx_byte);
                    valid_next  = 1'b1;
                    kind_next   = 1'b0;
                    data_next   = cmd.rx_byte;
                    status_next = ST_OK;
                end
                OP_STATUS: begin
                    valid_next  = 1'b1;
                    kind_next   = 1'b1;
                    data_next   = 8'h00;
                    status_next = cmd.status;
                end
                OP_CRC_HI: begin
                    crc_hi_next = cmd.rx_byte;
                end
                OP_CRC_LO: begin
                    valid_next  = 1'b1;
                    kind_next   = 1'b1;
                    data_next   = 8'h00;
                    status_next = ({crc_hi_reg, cmd.rx_byte} == crc_reg) ? ST_OK : ST_BAD_CRC;
                end
                default: begin
                    crc_next = crc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            crc_reg    <= SEED_RESET;
            crc_hi_reg <= 8'h00;
        end else begin
            valid_reg  <= valid_next;
            crc_reg    <= crc_next;
            crc_hi_reg <= crc_hi_next;
        end
        kind_reg   <= kind_next;
        data_reg   <= data_next;
        status_reg <= status_next;
    end

    assign out_valid  = valid_reg;
    assign out_kind   = kind_reg;
    assign out_data   = data_reg;
    assign out_status = status_reg;

endmodule
`default_nettype wire

// ===== design/framed_packet_receiver_crc16_core.sv =====
// Top level of the framed packet receiver with CRC16-CCITT check.
// Depends on fprc_pkg, fprc_front, fprc_cmd_fifo and fprc_back.
//
// Usage: received bytes enter on the s_ stream, one byte per request. Bytes are
// dropped until a 0x01 start byte; then a big-endian length, 0x02, the message,
// 0x03 and a big-endian CRC16-CCITT follow. Each message byte leaves on the m_
// stream with m_tuser low; a frame ends with one status request with m_tuser
// high (ok, bad start of text, bad length, bad end of text or bad CRC).
// The user must write the CRC seed through crc_seed_we and crc_seed_wdata only
// while idle; the block does not enforce this. Throughput is one byte per cycle
// while m_tready is high. The framing stage places a command in the two-entry
// queue when its byte is accepted; the CRC stage then loads the output register
// that drives the m_ stream from it. When m_tready is low the output register
// holds, the queue fills and s_tready drops once both entries are taken.
// Reset returns the framer to hunting, empties the queue and the output
// register and sets the seed to 0xFFFF.
`timescale 1ns / 1ps
`default_nettype none
module framed_packet_receiver_crc16_core
    import fprc_pkg::*;
#(
    parameter int MAX_PACKET = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        crc_seed_we,
    input  wire logic [15:0] crc_seed_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] data, [10:8] status, zero above
    output logic             m_tuser    // [0] kind
);

    logic [15:0] seed_reg;
    cmd_t        front_cmd, queue_cmd;
    logic        front_push, queue_full, queue_empty, queue_pop;
    logic [7:0]  out_data;
    logic [2:0]  out_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= SEED_RESET;
        end else if (crc_seed_we) begin
            seed_reg <= crc_seed_wdata;
        end
    end

    assign s_tready = !queue_full;

    fprc_front #(
        .MAX_PACKET(MAX_PACKET)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid && s_tready),
        .in_byte  (s_tdata),
        .cmd      (front_cmd),
        .cmd_push (front_push)
    );

    fprc_cmd_fifo u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (front_push),
        .push_cmd (front_cmd),
        .full     (queue_full),
        .empty    (queue_empty),
        .pop      (queue_pop),
        .pop_cmd  (queue_cmd)
    );

    fprc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .crc_seed   (seed_reg),
        .cmd_valid  (!queue_empty),
        .cmd        (queue_cmd),
        .cmd_pop    (queue_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (m_tuser),
        .out_data   (out_data),
        .out_status (out_status)
    );

    assign m_tdata = {5'b0, out_status, out_data};

    a_payload_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[10:8] == 3'd0)
        else $error("payload result carries a nonzero status");

    a_status_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[7:0] == 8'h00)
        else $error("status result carries nonzero data");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[10:8] <= 3'd4)
        else $error("status code out of range");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> !queue_empty && !m_tready || $past(!m_tready) || !queue_empty)
        else $error("input stalled with an empty queue");

endmodule
`default_nettype wire

// ===== tb/sv/framed_packet_receiver_crc16_core_test.sv =====
// Self-checking testbench for framed_packet_receiver_crc16_core: a directed table, then random
// frames (good, broken and noise) under three CRC seeds, with random stalls on both streams.
// Depends on fprc_pkg and the block's RTL.
`timescale 1ns / 1ps
module framed_packet_receiver_crc16_core_test;
    import fprc_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int MAX_PACKET_LEN = 64;
    localparam int PHASE_ITEMS    = 600;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_AT        = 200;
    localparam int HOLD_CYCLES    = 300;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DIRECTED_ROWS  = 24;

    typedef enum logic [2:0] {
        RX_HUNT, RX_LEN_HI, RX_LEN_LO, RX_STX, RX_BODY, RX_ETX, RX_CRC_HI, RX_CRC_LO
    } rx_phase_e;

    typedef enum logic [1:0] {SRC_LIT, SRC_CRC_HI, SRC_CRC_LO} byte_src_e;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} row_check_e;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        status_t    status;
    } frame_result_t;

    typedef struct packed {
        byte_src_e     src;
        logic [7:0]    value;
        row_check_e    chk;
        frame_result_t want;
    } stim_row_t;

    localparam frame_result_t NONE_RES = '{1'b0, 8'h00, ST_OK};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        crc_seed_we = 1'b0;
    logic [15:0] crc_seed_wdata = 16'h0000;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    rx_phase_e   rx_phase = RX_HUNT;
    int          body_count = 0;
    logic [15:0] frame_len = 16'h0000;
    logic [15:0] crc_acc = SEED_RESET;
    logic [7:0]  crc_hi_byte = 8'h00;
    logic [15:0] seed_cfg = SEED_RESET;

    frame_result_t pending_results[$];
    stim_row_t     directed_plan [DIRECTED_ROWS];
    int            items_sent = 0;
    int            results_seen = 0;
    int            mismatches = 0;
    bit            tx_fast = 1'b0;
    int unsigned   cycle_count = 0;

    framed_packet_receiver_crc16_core #(
        .MAX_PACKET(MAX_PACKET_LEN)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .crc_seed_we   (crc_seed_we),
        .crc_seed_wdata(crc_seed_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("framed_packet_receiver_crc16_core: mismatch");
        $finish;
    end

    function automatic logic [15:0] crc16_ccitt_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc;
        for (int k = 7; k >= 0; k--) begin
            if (c[15] ^ b[k]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, output frame_result_t r);
        int body_len;
        body_len = (int'(frame_len) >= MinPacket) ? int'(frame_len) - MinPacket : 0;
        r = '{1'b1, 8'h00, ST_OK};
        case (rx_phase)
            RX_HUNT: begin
                if (b == BYTE_SOH) begin
                    crc_acc = crc16_ccitt_step(seed_cfg, b);
                    frame_len = 16'h0000;
                    body_count = 0;
                    rx_phase = RX_LEN_HI;
                end
                return 1'b0;
            end
            RX_LEN_HI: begin
                frame_len = {b, 8'h00};
                crc_acc = crc16_ccitt_step(crc_acc, b);
                rx_phase = RX_LEN_LO;
                return 1'b0;
            end
            RX_LEN_LO: begin
                frame_len = {frame_len[15:8], b};
                crc_acc = crc16_ccitt_step(crc_acc, b);
                if (int'(frame_len) < MinPacket || int'(frame_len) > MAX_PACKET_LEN) begin
                    r.status = ST_BAD_LEN;
                    rx_phase = RX_HUNT;
                    return 1'b1;
                end
                rx_phase = RX_STX;
                return 1'b0;
            end
            RX_STX: begin
                if (b != BYTE_STX) begin
                    r.status = ST_BAD_STX;
                    rx_phase = RX_HUNT;
                    return 1'b1;
                end
                crc_acc = crc16_ccitt_step(crc_acc, b);
                body_count = 0;
                rx_phase = (body_len == 0) ? RX_ETX : RX_BODY;
                return 1'b0;
            end
            RX_BODY: begin
                crc_acc = crc16_ccitt_step(crc_acc, b);
                body_count++;
                if (body_count >= body_len) begin
                    rx_phase = RX_ETX;
                end
                r = '{1'b0, b, ST_OK};
                return 1'b1;
            end
            RX_ETX: begin
                if (b != BYTE_ETX) begin
                    r.status = ST_BAD_ETX;
                    rx_phase = RX_HUNT;
                    return 1'b1;
                end
                crc_acc = crc16_ccitt_step(crc_acc, b);
                rx_phase = RX_CRC_HI;
                return 1'b0;
            end
            RX_CRC_HI: begin
                crc_hi_byte = b;
                rx_phase = RX_CRC_LO;
                return 1'b0;
            end
            RX_CRC_LO: begin
                r.status = ({crc_hi_byte, b} == crc_acc) ? ST_OK : ST_BAD_CRC;
                rx_phase = RX_HUNT;
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    task automatic offer_byte(input logic [7:0] b, output bit has_res, output frame_result_t res);
        int gap;
        if ($urandom_range(0, 63) == 0) begin
            tx_fast = !tx_fast;
        end
        gap = tx_fast ? 0 : $urandom_range(0, 15);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        if (!(rx_phase == RX_HUNT && b != BYTE_SOH)) begin
            items_sent++;
        end
        has_res = deframe_byte(b, res);
    endtask

    task automatic offer_predicted(input logic [7:0] b);
        bit has_res;
        frame_result_t res;
        offer_byte(b, has_res, res);
        if (has_res) begin
            pending_results.push_back(res);
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [15:0] value);
        @(negedge aclk);
        crc_seed_we <= 1'b1;
        crc_seed_wdata <= value;
        @(negedge aclk);
        crc_seed_we <= 1'b0;
        seed_cfg = value;
    endtask

    task automatic send_random_frame();
        int shape;
        int pick;
        logic [15:0] frame_total;
        logic [15:0] flip;
        logic [7:0] b;
        shape = $urandom_range(0, 99);
        if (shape < 8) begin
            repeat ($urandom_range(1, 4)) offer_predicted(8'($urandom));
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            frame_total = 16'(MinPacket);
        end else if (pick < 25) begin
            frame_total = 16'(MAX_PACKET_LEN);
        end else if (pick < 70) begin
            frame_total = 16'($urandom_range(8, 16));
        end else begin
            frame_total = 16'($urandom_range(17, MAX_PACKET_LEN - 1));
        end
        if (shape < 14) begin
            case ($urandom_range(0, 3))
                0, 1: frame_total = 16'($urandom_range(0, MinPacket - 1));
                2: frame_total = 16'($urandom_range(MAX_PACKET_LEN + 1, 255));
                default: frame_total = 16'($urandom_range(256, 65535));
            endcase
        end
        offer_predicted(BYTE_SOH);
        offer_predicted(frame_total[15:8]);
        offer_predicted(frame_total[7:0]);
        if (shape < 14) begin
            return;
        end
        if (shape < 20) begin
            do b = 8'($urandom); while (b == BYTE_STX);
            offer_predicted(b);
            return;
        end
        offer_predicted(BYTE_STX);
        repeat (int'(frame_total) - MinPacket) offer_predicted(8'($urandom));
        if (shape < 26) begin
            do b = 8'($urandom); while (b == BYTE_ETX);
            offer_predicted(b);
            return;
        end
        offer_predicted(BYTE_ETX);
        flip = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000;
        offer_predicted(crc_acc[15:8] ^ flip[15:8]);
        offer_predicted(crc_acc[7:0] ^ flip[7:0]);
    endtask

    function automatic void report_field(input string field, input int want_v, input int got_v);
        mismatches++;
        $display("%0t ns: %s expected %0h, got %0h", $time, field, want_v, got_v);
    endfunction

    initial begin : result_sink
        frame_result_t got;
        frame_result_t want;
        int hold;
        bit rx_fast;
        bit hold_done;
        rx_fast = 1'b0;
        hold_done = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 31) == 0) begin
                rx_fast = !rx_fast;
            end
            if (results_seen == HOLD_AT && !hold_done) begin
                hold = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                hold = rx_fast ? 0 : $urandom_range(0, 15);
            end
            @(negedge aclk);
            if (hold != 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.kind = m_tuser;
            got.data = m_tdata[7:0];
            got.status = status_t'(m_tdata[10:8]);
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: expected no request, got kind %0d data %02h status %0d",
                         $time, got.kind, got.data, got.status);
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind) begin
                    report_field("kind", want.kind, got.kind);
                end
                if (got.data !== want.data) begin
                    report_field("data", want.data, got.data);
                end
                if (got.status !== want.status) begin
                    report_field("status", want.status, got.status);
                end
            end
        end
    end

    initial begin : stimulus
        stim_row_t row;
        logic [7:0] b;
        bit has_res;
        frame_result_t res;
        logic [15:0] seed_plan [3];
        seed_plan = '{16'h0000, 16'($urandom_range(1, 65534)), 16'hFFFF};
        directed_plan = '{
            '{SRC_LIT, 8'h00, CHK_NONE, NONE_RES},
            '{SRC_LIT, 8'h01, CHK_NONE, NONE_RES},
            '{SRC_LIT, 8'h00, CHK_NONE, NONE_RES},
            '{SRC_LIT, 8'h41, CHK_TYPED, '{1'b1, 8'h00, ST_BAD_LEN}},
            '{SRC_LIT, 8'h01, CHK_NONE, NONE_RES},
            '{SRC_LIT, 8'h00, CHK_NONE, NONE_RES},
            '{SRC_LIT, 8'h06, CHK_TYPED, '{1'b1, 8'h00, ST_BAD_LEN}},
            '{SRC_LIT, 8'h01, CHK_NONE, NONE_RES},
            '{SRC_LIT, 8'h00, CHK_NONE, NONE_RES},
            '{SRC_LIT, 8'h07, CHK_NONE, NONE_RES},
            '{SRC_LIT, 8'h01, CHK_TYPED, '{1'b1, 8'h00, ST_BAD_STX}},
            '{SRC_LIT, 8'h01, CHK_NONE, NONE_RES},
            '{SRC_LIT, 8'h00, CHK_NONE, NONE_RES},
            '{SRC_LIT, 8'h07, CHK_NONE, NONE_RES},
            '{SRC_LIT, 8'h02, CHK_NONE, NONE_RES},
            '{SRC_LIT, 8'hFF, CHK_TYPED, '{1'b1, 8'h00, ST_BAD_ETX}},
            '{SRC_LIT, 8'h01, CHK_NONE, NONE_RES},
            '{SRC_LIT, 8'h00, CHK_NONE, NONE_RES},
            '{SRC_LIT, 8'h08, CHK_NONE, NONE_RES},
            '{SRC_LIT, 8'h02, CHK_NONE, NONE_RES},
            '{SRC_LIT, 8'h01, CHK_TYPED, '{1'b0, 8'h01, ST_OK}},
            '{SRC_LIT, 8'h03, CHK_NONE, NONE_RES},
            '{SRC_CRC_HI, 8'h00, CHK_MODEL, NONE_RES},
            '{SRC_CRC_LO, 8'h00, CHK_MODEL, NONE_RES}
        };
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = directed_plan[i];
            case (row.src)
                SRC_CRC_HI: b = crc_acc[15:8] ^ row.value;
                SRC_CRC_LO: b = crc_acc[7:0] ^ row.value;
                default: b = row.value;
            endcase
            offer_byte(b, has_res, res);
            if (row.chk == CHK_TYPED) begin
                pending_results.push_back(row.want);
            end else if (row.chk == CHK_MODEL && has_res) begin
                pending_results.push_back(res);
            end
        end

        for (int p = 0; p < 3; p++) begin
            wait_drained();
            write_seed(seed_plan[p]);
            while (items_sent < (p + 1) * PHASE_ITEMS) begin
                send_random_frame();
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("framed_packet_receiver_crc16_core: match");
        end else begin
            $display("framed_packet_receiver_crc16_core: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/fprc_pkg.sv
design/fprc_front.sv
design/fprc_cmd_fifo.sv
design/fprc_back.sv
design/framed_packet_receiver_crc16_core.sv
tb/sv/framed_packet_receiver_crc16_core_test.sv
